// ===== sv/md5_pkg.sv =====
// Types, constants and round functions for the MD5 digest block.
package md5_pkg;

  localparam int unsigned CNT_W = 61;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] K_TAB [0:63] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // rotate amount, indexed by {round group, round mod 4}
  localparam logic [4:0] ROT_TAB [0:15] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } md5_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_ROT,
    S_ADD,
    S_DONE
  } md5_state_t;

  // which block is being compressed: message data, padded tail, length only
  typedef enum logic [1:0] {
    BLK_MSG,
    BLK_PAD,
    BLK_LEN
  } md5_blk_t;

  function automatic logic [3:0] md5_sel(input logic [5:0] r);
    logic [3:0] s;
    unique case (r[5:4])
      2'd0: s = r[3:0];
      2'd1: s = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2: s = 4'(r[3:0] * 4'd3 + 4'd5);
      2'd3: s = 4'(r[3:0] * 4'd7);
    endcase
    return s;
  endfunction

  function automatic logic [31:0] md5_f(input logic [5:0] r, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (r[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

// ===== sv/md5_message_digest.sv =====
// MD5 digest over a byte stream, one shared round unit under a small sequencer.
//
//   channel  | fields                              | handshake
//   ---------+-------------------------------------+------------------------
//   in_data  | data_byte, has_byte, last           | in_valid / in_ready
//   out_data | digest_a, digest_b, digest_c, digest_d | out_valid / out_ready
//
// A byte that does not complete a 64-byte block is stored while the sequencer
// stays idle. A full block runs a load step, then each round as a sum step and
// then a rotate/add step, then a chaining add. An end item costs one or two
// compressions, then the digest is handed over from the done state.
// Reset sets the chaining words and byte count to the start of a message.
// A digest waiting on out_ready does not stop the next message's bytes; only
// the following digest waits for the output register to free up.
module md5_message_digest import md5_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  md5_in_t  in_data,
  input  logic     in_valid,
  output logic     in_ready,
  output md5_out_t out_data,
  output logic     out_valid,
  input  logic     out_ready
);

  md5_state_t state, state_next;
  md5_blk_t   blk;
  logic       fin;

  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] t_sum;
  logic [5:0]  round;
  logic [CNT_W-1:0] cnt;
  logic [31:0] bw [0:15];
  logic [31:0] m_raw;
  md5_out_t    dig;
  logic        dig_valid;

  logic        in_acc, out_acc, slot_free;
  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic [3:0]  rd_addr, cur_w;
  logic [31:0] m_word, masked_w, pad_w;
  logic [31:0] t_sum_next, rot_res;
  logic [63:0] rot_dbl;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = dig_valid;
  assign out_data  = dig;
  assign out_acc   = dig_valid & out_ready;
  assign slot_free = ~dig_valid | out_ready;

  assign pos     = cnt[5:0];
  assign bit_len = {cnt, 3'b000};

  // next round's word is fetched during the rotate phase
  assign rd_addr = md5_sel((state == S_ROT) ? 6'(round + 6'd1) : 6'd0);
  assign cur_w   = md5_sel(round);

  // tail word holding the end byte: keep bytes below it, then 0x80, then zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < pos[1:0]) begin
        masked_w[8*i +: 8] = m_raw[8*i +: 8];
      end else if (2'(i) == pos[1:0]) begin
        masked_w[8*i +: 8] = PAD_BYTE;
      end else begin
        masked_w[8*i +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    if (cur_w < pos[5:2]) begin
      pad_w = m_raw;
    end else if (cur_w == pos[5:2]) begin
      pad_w = masked_w;
    end else if (pos[5:3] != 3'b111 && cur_w == 4'd14) begin
      pad_w = bit_len[31:0];
    end else if (pos[5:3] != 3'b111 && cur_w == 4'd15) begin
      pad_w = bit_len[63:32];
    end else begin
      pad_w = '0;
    end
  end

  always_comb begin
    unique case (blk)
      BLK_MSG: m_word = m_raw;
      BLK_PAD: m_word = pad_w;
      BLK_LEN: begin
        if (cur_w == 4'd14) begin
          m_word = bit_len[31:0];
        end else if (cur_w == 4'd15) begin
          m_word = bit_len[63:32];
        end else begin
          m_word = '0;
        end
      end
      default: m_word = m_raw;
    endcase
  end

  assign t_sum_next = wa + md5_f(round, wb, wc, wd) + K_TAB[round] + m_word;
  assign rot_dbl    = {t_sum, t_sum} << ROT_TAB[{round[5:4], round[1:0]}];
  assign rot_res    = rot_dbl[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.has_byte && pos == 6'd63) begin
            state_next = S_LOAD;
          end else if (in_data.last) begin
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: state_next = S_SUM;
      S_SUM:  state_next = S_ROT;
      S_ROT:  state_next = (round == 6'd63) ? S_ADD : S_SUM;
      S_ADD: begin
        unique case (blk)
          BLK_MSG: state_next = fin ? S_LOAD : S_IDLE;
          BLK_PAD: state_next = (pos[5:3] == 3'b111) ? S_LOAD : S_DONE;
          BLK_LEN: state_next = S_DONE;
          default: state_next = S_IDLE;
        endcase
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk       <= BLK_MSG;
      fin       <= 1'b0;
      round     <= '0;
      cnt       <= '0;
      dig_valid <= 1'b0;
      chain_a   <= H0;
      chain_b   <= H1;
      chain_c   <= H2;
      chain_d   <= H3;
    end else begin
      if (state == S_DONE && slot_free) begin
        dig_valid <= 1'b1;
      end else if (out_acc) begin
        dig_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.has_byte) begin
              cnt <= cnt + 1'b1;
            end
            blk <= (in_data.has_byte && pos == 6'd63) ? BLK_MSG : BLK_PAD;
            fin <= in_data.last;
          end
        end
        S_LOAD: round <= '0;
        S_SUM:  ;
        S_ROT:  round <= round + 6'd1;
        S_ADD: begin
          chain_a <= chain_a + wa;
          chain_b <= chain_b + wb;
          chain_c <= chain_c + wc;
          chain_d <= chain_d + wd;
          if (blk == BLK_MSG) begin
            blk <= BLK_PAD;
          end else if (blk == BLK_PAD) begin
            blk <= BLK_LEN;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            cnt       <= '0;
            chain_a   <= H0;
            chain_b   <= H1;
            chain_c   <= H2;
            chain_d   <= H3;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    m_raw <= bw[rd_addr];
    if (in_acc && in_data.has_byte) begin
      bw[pos[5:2]][8*pos[1:0] +: 8] <= in_data.data_byte;
    end
    unique case (state)
      S_LOAD: begin
        wa <= chain_a;
        wb <= chain_b;
        wc <= chain_c;
        wd <= chain_d;
      end
      S_SUM: t_sum <= t_sum_next;
      S_ROT: begin
        wa <= wd;
        wd <= wc;
        wc <= wb;
        wb <= wb + rot_res;
      end
      S_DONE: begin
        if (slot_free) begin
          dig.digest_a <= chain_a;
          dig.digest_b <= chain_b;
          dig.digest_c <= chain_c;
          dig.digest_d <= chain_d;
        end
      end
      default: ;
    endcase
  end

endmodule
